// File: rtl/mcssr_pkg.sv
// mcssr_pkg: shared types, constants and register codes for the soft-start ramp block
// used by the channel interfaces and every rtl module of the block
package mcssr_pkg;

  // field widths
  localparam int FULL_SPEED_W = 10;
  localparam int DUTY_W       = 16;
  localparam int STEP_CFG_W   = 10;
  localparam int MODE_W       = 3;
  localparam int PCT_IN_W     = 8;
  localparam int PCT_W        = 7;
  localparam int TIME_W       = 32;
  localparam int TGT_W        = 19;
  localparam int CMD_W        = 2;

  // internal widths
  localparam int ELAPSED_W    = 7;
  localparam int STEP_W       = ELAPSED_W + STEP_CFG_W;
  localparam int CAP_PROD_W   = DUTY_W + PCT_W;
  localparam int FS_PROD_W    = FULL_SPEED_W + PCT_W;
  localparam int Q_FRAC       = 8;
  localparam int FULL_NUM_W   = FS_PROD_W + Q_FRAC;
  localparam int HALF_NUM_W   = FS_PROD_W + Q_FRAC - 1;
  localparam int SPEED_W      = 18;

  // divide by 100 as multiply by ceil(2^32/100), exact for operands below 2^30
  localparam int                  RECIP_W     = 26;
  localparam int                  RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0]  RECIP_100   = 26'd42949673;

  localparam logic [PCT_W-1:0]     PCT_MAX    = 7'd100;
  localparam logic [TIME_W-1:0]    GAP_LIMIT  = 32'd100;
  localparam logic [ELAPSED_W-1:0] GAP_SUBST  = 7'd2;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MIN = 7'd1;
  localparam logic [6:0]           ROUND_HALF = 7'd50;

  // motion modes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FWD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BWD   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd4;

  // motor commands
  localparam logic [CMD_W-1:0] CMD_STOP_DISABLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP_HOLD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN          = 2'd2;

  // configuration registers
  localparam int               ADDR_W         = 4;
  localparam int               DATA_W         = 32;
  localparam logic [1:0]       REG_FULL_SPEED = 2'd0;
  localparam logic [1:0]       REG_DUTY_MAX   = 2'd1;
  localparam logic [1:0]       REG_STEP       = 2'd2;

  localparam logic [FULL_SPEED_W-1:0] FULL_SPEED_RST = 10'd230;
  localparam logic [DUTY_W-1:0]       DUTY_MAX_RST   = 16'd1000;
  localparam logic [STEP_CFG_W-1:0]   STEP_RST       = 10'd50;

  // work queue between front and back
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

  typedef struct packed {
    logic [FULL_SPEED_W-1:0] full_speed;
    logic [DUTY_W-1:0]       duty_max;
    logic [STEP_CFG_W-1:0]   step_per_ms;
  } cfg_t;

  typedef struct packed {
    logic                  clear;
    logic [MODE_W-1:0]     mode;
    logic [CMD_W-1:0]      motor_command;
    logic                  speed_loop_reset;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [CAP_PROD_W-1:0] p_cap;
    logic [FS_PROD_W-1:0]  p_fs;
  } stage_a_t;

  typedef struct packed {
    logic                 clear;
    logic [MODE_W-1:0]    mode;
    logic [CMD_W-1:0]     motor_command;
    logic                 speed_loop_reset;
    logic [STEP_W-1:0]    step;
    logic [DUTY_W-1:0]    cap;
    logic [SPEED_W-1:0]   full;
    logic [SPEED_W-1:0]   half;
  } work_t;

endpackage

// File: rtl/mcssr_cmd_if.sv
// mcssr_cmd_if: valid/ready channel carrying one motion command
// depends on mcssr_pkg for field widths
interface mcssr_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              stop_req;
  logic [mcssr_pkg::MODE_W-1:0]      drive_mode;
  logic [mcssr_pkg::PCT_IN_W-1:0]    speed_pct;
  logic [mcssr_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, stop_req, drive_mode, speed_pct, now_ms,
                  input ready);
  modport sink (input valid, stop_req, drive_mode, speed_pct, now_ms,
                output ready);
endinterface

// File: rtl/mcssr_res_if.sv
// mcssr_res_if: valid/ready channel carrying one ramp result
// depends on mcssr_pkg for field widths
interface mcssr_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcssr_pkg::TGT_W-1:0]  left_speed;
  logic signed [mcssr_pkg::TGT_W-1:0]  right_speed;
  logic [mcssr_pkg::DUTY_W-1:0]        duty_limit;
  logic [mcssr_pkg::CMD_W-1:0]         motor_command;
  logic                                speed_loop_reset;

  modport source (output valid, left_speed, right_speed, duty_limit, motor_command,
                  speed_loop_reset, input ready);
  modport sink (input valid, left_speed, right_speed, duty_limit, motor_command,
                speed_loop_reset, output ready);
endinterface

// File: rtl/mcssr_front.sv
// mcssr_front: accepts commands, classifies them, tracks mode and time, scales
// percent into cap and speed targets over two stages; depends on mcssr_pkg, mcssr_cmd_if
module mcssr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  mcssr_pkg::cfg_t      cfg,
  mcssr_cmd_if.sink            cmd,
  output logic                 push_valid,
  input  logic                 push_ready,
  output mcssr_pkg::work_t     push_data
);

  logic                                  a_valid;
  logic                                  b_valid;
  logic                                  a_free;
  logic                                  b_free;
  mcssr_pkg::stage_a_t                   a_reg;
  mcssr_pkg::stage_a_t                   a_next;
  mcssr_pkg::work_t                      b_reg;
  mcssr_pkg::work_t                      b_next;
  logic [mcssr_pkg::MODE_W-1:0]          prev_mode;
  logic [mcssr_pkg::TIME_W-1:0]          prev_time;
  logic [mcssr_pkg::TIME_W-1:0]          elapsed_raw;
  logic [mcssr_pkg::PCT_W-1:0]           pct_sat;
  logic                                  accept;

  logic [mcssr_pkg::FULL_NUM_W-1:0]      full_num;
  logic [mcssr_pkg::HALF_NUM_W-1:0]      half_num;
  logic [mcssr_pkg::CAP_PROD_W+mcssr_pkg::RECIP_W-1:0] cap_prod;
  logic [mcssr_pkg::FULL_NUM_W+mcssr_pkg::RECIP_W-1:0] full_prod;
  logic [mcssr_pkg::HALF_NUM_W+mcssr_pkg::RECIP_W-1:0] half_prod;

  assign b_free     = !b_valid || push_ready;
  assign a_free     = !a_valid || b_free;
  assign cmd.ready  = a_free;
  assign accept     = cmd.valid && a_free;
  assign push_valid = b_valid;
  assign push_data  = b_reg;

  // stage a: classify, elapsed time, percent products
  always_comb begin
    elapsed_raw = cmd.now_ms - prev_time;
    pct_sat = (cmd.speed_pct > mcssr_pkg::PCT_IN_W'(mcssr_pkg::PCT_MAX)) ?
              mcssr_pkg::PCT_MAX : cmd.speed_pct[mcssr_pkg::PCT_W-1:0];

    a_next.clear = cmd.stop_req || (cmd.drive_mode == mcssr_pkg::MODE_IDLE);
    a_next.mode  = cmd.drive_mode;

    if (cmd.stop_req) begin
      a_next.motor_command = mcssr_pkg::CMD_STOP_DISABLE;
    end else begin
      case (cmd.drive_mode)
        mcssr_pkg::MODE_FWD,
        mcssr_pkg::MODE_BWD,
        mcssr_pkg::MODE_LEFT,
        mcssr_pkg::MODE_RIGHT: a_next.motor_command = mcssr_pkg::CMD_RUN;
        default:               a_next.motor_command = mcssr_pkg::CMD_STOP_HOLD;
      endcase
    end

    a_next.speed_loop_reset = a_next.clear || (cmd.drive_mode != prev_mode);

    // long gaps count as a short one, no gap still moves one step
    if (elapsed_raw > mcssr_pkg::GAP_LIMIT) begin
      a_next.elapsed = mcssr_pkg::GAP_SUBST;
    end else if (elapsed_raw == '0) begin
      a_next.elapsed = mcssr_pkg::ELAPSED_MIN;
    end else begin
      a_next.elapsed = elapsed_raw[mcssr_pkg::ELAPSED_W-1:0];
    end

    a_next.p_cap = mcssr_pkg::CAP_PROD_W'(cfg.duty_max) *
                   mcssr_pkg::CAP_PROD_W'(pct_sat);
    a_next.p_fs  = mcssr_pkg::FS_PROD_W'(cfg.full_speed) *
                   mcssr_pkg::FS_PROD_W'(pct_sat);
  end

  // stage b: step size and divide by 100 through the reciprocal
  always_comb begin
    full_num  = {a_reg.p_fs, {mcssr_pkg::Q_FRAC{1'b0}}} +
                mcssr_pkg::FULL_NUM_W'(mcssr_pkg::ROUND_HALF);
    half_num  = {a_reg.p_fs, {(mcssr_pkg::Q_FRAC-1){1'b0}}} +
                mcssr_pkg::HALF_NUM_W'(mcssr_pkg::ROUND_HALF);
    cap_prod  = (mcssr_pkg::CAP_PROD_W+mcssr_pkg::RECIP_W)'(a_reg.p_cap) *
                (mcssr_pkg::CAP_PROD_W+mcssr_pkg::RECIP_W)'(mcssr_pkg::RECIP_100);
    full_prod = (mcssr_pkg::FULL_NUM_W+mcssr_pkg::RECIP_W)'(full_num) *
                (mcssr_pkg::FULL_NUM_W+mcssr_pkg::RECIP_W)'(mcssr_pkg::RECIP_100);
    half_prod = (mcssr_pkg::HALF_NUM_W+mcssr_pkg::RECIP_W)'(half_num) *
                (mcssr_pkg::HALF_NUM_W+mcssr_pkg::RECIP_W)'(mcssr_pkg::RECIP_100);

    b_next.clear            = a_reg.clear;
    b_next.mode             = a_reg.mode;
    b_next.motor_command    = a_reg.motor_command;
    b_next.speed_loop_reset = a_reg.speed_loop_reset;
    b_next.step = mcssr_pkg::STEP_W'(a_reg.elapsed) * mcssr_pkg::STEP_W'(cfg.step_per_ms);
    b_next.cap  = cap_prod[mcssr_pkg::RECIP_SHIFT +: mcssr_pkg::DUTY_W];
    b_next.full = full_prod[mcssr_pkg::RECIP_SHIFT +: mcssr_pkg::SPEED_W];
    b_next.half = half_prod[mcssr_pkg::RECIP_SHIFT +: mcssr_pkg::SPEED_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      prev_mode <= mcssr_pkg::MODE_IDLE;
      prev_time <= '0;
    end else begin
      if (a_free) begin
        a_valid <= cmd.valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (accept) begin
        prev_mode <= a_next.clear ? mcssr_pkg::MODE_IDLE : cmd.drive_mode;
        // time only moves when the command is not a stop or idle
        if (!a_next.clear) begin
          prev_time <= cmd.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_reg <= a_next;
    end
    if (a_valid && b_free) begin
      b_reg <= b_next;
    end
  end

endmodule

// File: rtl/mcssr_queue.sv
// mcssr_queue: short register queue of classified work between front and back
// depends on mcssr_pkg for the entry type and depth
module mcssr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  mcssr_pkg::work_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mcssr_pkg::work_t  pop_data
);

  mcssr_pkg::work_t                entries [mcssr_pkg::QUEUE_DEPTH];
  logic [mcssr_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [mcssr_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [mcssr_pkg::QUEUE_AW:0]    count;
  logic                            push;
  logic                            pop;

  assign push_ready = (count != (mcssr_pkg::QUEUE_AW+1)'(mcssr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (mcssr_pkg::QUEUE_AW+1)'(mcssr_pkg::QUEUE_DEPTH))
    else $error("work queue count past depth");

endmodule

// File: rtl/mcssr_back.sv
// mcssr_back: applies the ramp update to queued work and holds the result register
// depends on mcssr_pkg, mcssr_res_if
module mcssr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  mcssr_pkg::work_t  pop_data,
  mcssr_res_if.source       res
);

  logic [mcssr_pkg::DUTY_W-1:0]       ramp;
  logic [mcssr_pkg::DUTY_W-1:0]       ramp_next;
  logic [mcssr_pkg::DUTY_W-1:0]       base;
  logic [mcssr_pkg::DUTY_W-1:0]       diff;
  logic                               pop;
  logic signed [mcssr_pkg::TGT_W-1:0] full_s;
  logic signed [mcssr_pkg::TGT_W-1:0] half_s;
  logic signed [mcssr_pkg::TGT_W-1:0] left_next;
  logic signed [mcssr_pkg::TGT_W-1:0] right_next;
  logic [mcssr_pkg::DUTY_W-1:0]       duty_next;

  assign pop_ready = !res.valid || res.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    // a mode change restarts the ramp from zero before slewing
    base = pop_data.speed_loop_reset ? '0 : ramp;
    diff = '0;
    if (pop_data.clear) begin
      ramp_next = '0;
    end else if (base < pop_data.cap) begin
      diff = pop_data.cap - base;
      ramp_next = (mcssr_pkg::STEP_W'(diff) > pop_data.step) ?
                  base + pop_data.step[mcssr_pkg::DUTY_W-1:0] : pop_data.cap;
    end else if (base > pop_data.cap) begin
      diff = base - pop_data.cap;
      ramp_next = (mcssr_pkg::STEP_W'(diff) > pop_data.step) ?
                  base - pop_data.step[mcssr_pkg::DUTY_W-1:0] : pop_data.cap;
    end else begin
      ramp_next = base;
    end
  end

  always_comb begin
    full_s = $signed({1'b0, pop_data.full});
    half_s = $signed({1'b0, pop_data.half});
    left_next  = '0;
    right_next = '0;
    duty_next  = '0;
    if (!pop_data.clear) begin
      case (pop_data.mode)
        mcssr_pkg::MODE_FWD: begin
          left_next  = full_s;
          right_next = full_s;
          duty_next  = ramp_next;
        end
        mcssr_pkg::MODE_BWD: begin
          left_next  = -full_s;
          right_next = -full_s;
          duty_next  = ramp_next;
        end
        mcssr_pkg::MODE_LEFT: begin
          left_next  = -half_s;
          right_next = half_s;
          duty_next  = ramp_next;
        end
        mcssr_pkg::MODE_RIGHT: begin
          left_next  = half_s;
          right_next = -half_s;
          duty_next  = ramp_next;
        end
        default: begin
          left_next  = '0;
          right_next = '0;
          duty_next  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      ramp      <= '0;
    end else begin
      if (pop) begin
        res.valid <= 1'b1;
        ramp      <= ramp_next;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.left_speed       <= left_next;
      res.right_speed      <= right_next;
      res.duty_limit       <= duty_next;
      res.motor_command    <= pop_data.motor_command;
      res.speed_loop_reset <= pop_data.speed_loop_reset;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    pop && pop_data.clear |=> ramp == '0)
    else $error("ramp not cleared after stop");

  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.duty_limit != '0 |-> res.motor_command == mcssr_pkg::CMD_RUN)
    else $error("duty shown while not running");

  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.motor_command == mcssr_pkg::CMD_STOP_DISABLE |->
      res.speed_loop_reset && res.left_speed == '0 && res.right_speed == '0)
    else $error("emergency result not fully stopped");

endmodule

// File: rtl/motion_command_soft_start_ramp.sv
// motion_command_soft_start_ramp: top level with configuration registers and the
// front, queue and back parts; depends on mcssr_pkg, mcssr_cmd_if, mcssr_res_if
//
// Takes one motion command per clock on cmd while res is ready, and returns one
// result per command on res, in order. An accepted command passes stage a,
// stage b, the queue and the result register. Sustained rate is one command per
// cycle, set by the single ramp register updated once per transaction in the
// back part. A two-entry queue and the result register let cmd keep accepting
// while a result waits. Registers at byte addresses 0 (full_speed), 4 (duty_max)
// and 8 (step_per_ms) may only be written while no command is in flight.
module motion_command_soft_start_ramp (
  input  logic                            clk,
  input  logic                            rst,
  mcssr_cmd_if.sink                       cmd,
  mcssr_res_if.source                     res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcssr_pkg::ADDR_W-1:0]    paddr,
  input  logic [mcssr_pkg::DATA_W-1:0]    pwdata,
  output logic [mcssr_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  mcssr_pkg::cfg_t   cfg;
  logic              cfg_write;
  logic              push_valid;
  logic              push_ready;
  mcssr_pkg::work_t  push_data;
  logic              pop_valid;
  logic              pop_ready;
  mcssr_pkg::work_t  pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_speed  <= mcssr_pkg::FULL_SPEED_RST;
      cfg.duty_max    <= mcssr_pkg::DUTY_MAX_RST;
      cfg.step_per_ms <= mcssr_pkg::STEP_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        mcssr_pkg::REG_FULL_SPEED: cfg.full_speed  <= pwdata[mcssr_pkg::FULL_SPEED_W-1:0];
        mcssr_pkg::REG_DUTY_MAX:   cfg.duty_max    <= pwdata[mcssr_pkg::DUTY_W-1:0];
        mcssr_pkg::REG_STEP:       cfg.step_per_ms <= pwdata[mcssr_pkg::STEP_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mcssr_pkg::REG_FULL_SPEED: prdata = mcssr_pkg::DATA_W'(cfg.full_speed);
      mcssr_pkg::REG_DUTY_MAX:   prdata = mcssr_pkg::DATA_W'(cfg.duty_max);
      mcssr_pkg::REG_STEP:       prdata = mcssr_pkg::DATA_W'(cfg.step_per_ms);
      default:                   prdata = '0;
    endcase
  end

  mcssr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mcssr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mcssr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (res)
  );

endmodule
